>>> hdl/mtb_pkg.sv
// ----------------------------------------------------------------------------
// mtb_pkg: shared types and constants of the morph target blend unit
// Command codes, the queued item format and the back end state encoding.
// ----------------------------------------------------------------------------
package mtb_pkg;

  localparam int MAX_KEYS   = 16;
  localparam int MAX_VERTS  = 1024;
  localparam int KEY_W      = $clog2(MAX_KEYS);
  localparam int VTX_W      = $clog2(MAX_VERTS);
  localparam int KCNT_W     = 5;
  localparam int COORD_W    = 32;
  localparam int WEIGHT_W   = 16;
  localparam int RAMP_W     = 16;
  localparam int ACC_W      = 48;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] CMD_SET_TARGET = 3'd0;
  localparam logic [2:0] CMD_SET_RAMP   = 3'd1;
  localparam logic [2:0] CMD_ADVANCE    = 3'd2;
  localparam logic [2:0] CMD_ADD_VERTEX = 3'd3;
  localparam logic [2:0] CMD_READ       = 3'd4;

  typedef enum logic [2:0] {
    OP_TARGET,
    OP_RAMP,
    OP_ADVANCE,
    OP_ADD,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic [KEY_W-1:0]           key;
    logic [VTX_W-1:0]           vtx;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic signed [WEIGHT_W-1:0] weight;
    logic [RAMP_W-1:0]          ramp;
  } item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_READ,
    ST_EASE,
    ST_EASE_DIV,
    ST_EASE_END
  } bstate_t;

endpackage

>>> hdl/mtb_front.sv
// ----------------------------------------------------------------------------
// mtb_front: command intake
// Decodes commands, drops those with no effect and queues the rest.
// ----------------------------------------------------------------------------
module mtb_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [2:0]               command,
  input  logic [mtb_pkg::KEY_W-1:0] key_index,
  input  logic [mtb_pkg::VTX_W-1:0] vertex_index,
  input  logic signed [31:0]       coord_x,
  input  logic signed [31:0]       coord_y,
  input  logic signed [31:0]       coord_z,
  input  logic signed [15:0]       target_weight,
  input  logic [15:0]              ramp_frames,
  input  logic [mtb_pkg::KCNT_W-1:0] keys_used,
  output logic                     q_valid,
  output mtb_pkg::item_t           q_item,
  input  logic                     q_pop
);
  import mtb_pkg::*;

  item_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;
  logic               keep;
  logic               do_push;
  logic               do_pop;
  item_t              item_in;

  always_comb begin
    item_in = '0;
    item_in.key    = key_index;
    item_in.vtx    = vertex_index;
    item_in.x      = coord_x;
    item_in.y      = coord_y;
    item_in.z      = coord_z;
    item_in.weight = target_weight;
    item_in.ramp   = ramp_frames;
    keep = 1'b1;
    case (command)
      CMD_SET_TARGET: item_in.op = OP_TARGET;
      CMD_SET_RAMP:   item_in.op = OP_RAMP;
      CMD_ADVANCE:    item_in.op = OP_ADVANCE;
      CMD_ADD_VERTEX: begin
        item_in.op = OP_ADD;
        // drop vertices of keys not in use
        keep = ({1'b0, key_index} < keys_used);
      end
      CMD_READ:       item_in.op = OP_READ;
      default:        keep = 1'b0;
    endcase
  end

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = queue[rd_ptr];
  assign do_push = push && !full && keep;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) queue[wr_ptr] <= item_in;
  end

endmodule

>>> hdl/mtb_div.sv
// ----------------------------------------------------------------------------
// mtb_div: restoring divider
// Unsigned 17 by 16 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtb_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [16:0] quotient
);
  import mtb_pkg::*;

  logic [16:0] quo;
  logic [16:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [16:0] shifted;
  logic        fits;

  assign shifted  = {rem[15:0], quo[16]};
  assign fits     = (shifted >= {1'b0, divisor});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd17;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? (shifted - {1'b0, divisor}) : shifted;
      quo <= {quo[15:0], fits};
    end
  end

endmodule

>>> hdl/mtb_back.sv
// ----------------------------------------------------------------------------
// mtb_back: command execution
// Holds weights and accumulators, eases weights, accumulates and reads.
// ----------------------------------------------------------------------------
module mtb_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [mtb_pkg::KCNT_W-1:0] keys_used,
  input  logic                       q_valid,
  input  mtb_pkg::item_t             q_item,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [31:0]         blend_x,
  output logic signed [31:0]         blend_y,
  output logic signed [31:0]         blend_z,
  output logic                       saturated
);
  import mtb_pkg::*;

  localparam logic signed [ACC_W:0] ACC_HI = (ACC_W+1)'((64'sd1 <<< (ACC_W-1)) - 1);
  localparam logic signed [ACC_W:0] ACC_LO = -ACC_HI - 1;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

  bstate_t state, state_next;

  logic signed [WEIGHT_W-1:0] goal_w [MAX_KEYS];
  logic signed [WEIGHT_W-1:0] cur_w  [MAX_KEYS];
  logic [RAMP_W-1:0]          ramp;
  logic [KCNT_W-1:0]          k;
  logic [VTX_W-1:0]           clr_addr;
  logic                       neg;

  logic signed [ACC_W-1:0] mem_x [MAX_VERTS];
  logic signed [ACC_W-1:0] mem_y [MAX_VERTS];
  logic signed [ACC_W-1:0] mem_z [MAX_VERTS];
  logic signed [ACC_W-1:0] rd_x, rd_y, rd_z;
  logic signed [ACC_W-1:0] prod_x, prod_y, prod_z;
  logic [VTX_W-1:0]        item_vtx;

  logic                    mem_we;
  logic [VTX_W-1:0]        mem_wa;
  logic signed [ACC_W-1:0] wd_x, wd_y, wd_z;

  logic [KEY_W-1:0]           wsel;
  logic signed [WEIGHT_W-1:0] wsel_cur;
  logic signed [WEIGHT_W:0]   delta;
  logic [16:0]                mag;
  logic                       div_start;
  logic                       div_done;
  logic [16:0]                div_q;
  logic                       out_valid;
  logic                       k_done;
  logic                       sat_x, sat_y, sat_z;

  function automatic logic signed [ACC_W-1:0] acc_sum(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] p
  );
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + ((ACC_W+1)'(p >>> 14));
    if (s > ACC_HI)      acc_sum = ACC_W'(ACC_HI);
    else if (s < ACC_LO) acc_sum = ACC_W'(ACC_LO);
    else                 acc_sum = s[ACC_W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > SAT_HI)      sat32 = 32'sh7fffffff;
    else if (v < SAT_LO) sat32 = 32'sh80000000;
    else                 sat32 = v[31:0];
  endfunction

  mtb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (ramp),
    .done     (div_done),
    .quotient (div_q)
  );

  assign wsel     = (state == ST_IDLE) ? q_item.key : k[KEY_W-1:0];
  assign wsel_cur = cur_w[wsel];
  assign delta    = {goal_w[k[KEY_W-1:0]][WEIGHT_W-1], goal_w[k[KEY_W-1:0]]}
                  - {wsel_cur[WEIGHT_W-1], wsel_cur};
  assign mag      = delta[WEIGHT_W] ? 17'(-delta) : 17'(delta);
  assign k_done   = (k >= keys_used);
  assign empty    = !out_valid;
  assign sat_x    = (rd_x > SAT_HI) || (rd_x < SAT_LO);
  assign sat_y    = (rd_y > SAT_HI) || (rd_y < SAT_LO);
  assign sat_z    = (rd_z > SAT_HI) || (rd_z < SAT_LO);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == VTX_W'(MAX_VERTS-1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            OP_ADD:     state_next = ST_ADD;
            OP_READ:    if (!out_valid) state_next = ST_READ;
            OP_ADVANCE: state_next = ST_EASE;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD:      state_next = ST_IDLE;
      ST_READ:     state_next = ST_IDLE;
      ST_EASE: begin
        if (k_done) state_next = ST_EASE_END;
        else if (ramp != '0) state_next = ST_EASE_DIV;
      end
      ST_EASE_DIV: if (div_done) state_next = ST_EASE;
      ST_EASE_END: state_next = ST_CLEAR;
      default:     state_next = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = clr_addr;
    wd_x      = '0;
    wd_y      = '0;
    wd_z      = '0;
    case (state)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE:  q_pop = q_valid && !(q_item.op == OP_READ && out_valid);
      ST_ADD: begin
        mem_we = 1'b1;
        mem_wa = item_vtx;
        wd_x   = acc_sum(rd_x, prod_x);
        wd_y   = acc_sum(rd_y, prod_y);
        wd_z   = acc_sum(rd_z, prod_z);
      end
      ST_EASE:  div_start = !k_done && (ramp != '0);
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // accumulator memories
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[mem_wa] <= wd_x;
      mem_y[mem_wa] <= wd_y;
      mem_z[mem_wa] <= wd_z;
    end
    rd_x <= mem_x[q_item.vtx];
    rd_y <= mem_y[q_item.vtx];
    rd_z <= mem_z[q_item.vtx];
  end

  // products of the popped vertex, used in the following cycle
  always_ff @(posedge clk) begin
    prod_x   <= q_item.x * wsel_cur;
    prod_y   <= q_item.y * wsel_cur;
    prod_z   <= q_item.z * wsel_cur;
    item_vtx <= q_item.vtx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_KEYS; i++) begin
        goal_w[i] <= '0;
        cur_w[i]  <= '0;
      end
      ramp      <= '0;
      k         <= '0;
      clr_addr  <= '0;
      neg       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: clr_addr <= clr_addr + 1'b1;
        ST_IDLE: begin
          if (q_pop) begin
            case (q_item.op)
              OP_TARGET:  goal_w[q_item.key] <= q_item.weight;
              OP_RAMP:    ramp <= q_item.ramp;
              OP_ADVANCE: k <= '0;
              default:    ;
            endcase
          end
        end
        ST_READ: out_valid <= 1'b1;
        ST_EASE: begin
          if (!k_done) begin
            if (ramp == '0) begin
              cur_w[k[KEY_W-1:0]] <= goal_w[k[KEY_W-1:0]];
              k <= k + 1'b1;
            end else begin
              neg <= delta[WEIGHT_W];
            end
          end
        end
        ST_EASE_DIV: begin
          if (div_done) begin
            cur_w[k[KEY_W-1:0]] <= WEIGHT_W'({wsel_cur[WEIGHT_W-1], wsel_cur}
                                   + (neg ? -div_q : div_q));
            k <= k + 1'b1;
          end
        end
        ST_EASE_END: begin
          if (ramp != '0) ramp <= ramp - 1'b1;
          clr_addr <= '0;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      blend_x   <= sat32(rd_x);
      blend_y   <= sat32(rd_y);
      blend_z   <= sat32(rd_z);
      saturated <= sat_x || sat_y || sat_z;
    end
  end

endmodule

>>> hdl/morph_target_blend_unit.sv
// ----------------------------------------------------------------------------
// morph_target_blend_unit: blend shape weighted sum
// Eases per-key weights and sums weighted key vertices per mesh vertex.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter through push/full; a transfer happens when push is high
//   and full is low. A four-entry command queue sits ahead of the execution
//   engine, so commands are taken while a read result is still pending.
//   Read results leave through empty/pop; the result on blend_x/y/z and
//   saturated holds while empty is low and leaves on pop.
//   Steps per command in the engine: set target and set ramp apply on pop;
//   add vertex reads the accumulator and forms the product, then writes the
//   sum back; read vertex reads it, then loads the result register. Advance
//   runs a serial division per key in use while the ramp is running (one
//   quotient bit a cycle), a copy per key otherwise, then a clearing sweep
//   of the accumulator memories, one vertex a cycle. Reset runs the same
//   sweep; commands queue meanwhile. A stalled receiver holds the result
//   register; a following read waits in the queue until the result is
//   popped, and the queue then fills. The user must write key_count through
//   cfg_write/cfg_data only while the unit is idle; this is not enforced.
// ----------------------------------------------------------------------------
module morph_target_blend_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [4:0]           cfg_data,
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           command,
  input  logic [3:0]           key_index,
  input  logic [9:0]           vertex_index,
  input  logic signed [31:0]   coord_x,
  input  logic signed [31:0]   coord_y,
  input  logic signed [31:0]   coord_z,
  input  logic signed [15:0]   target_weight,
  input  logic [15:0]          ramp_frames,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [31:0]   blend_x,
  output logic signed [31:0]   blend_y,
  output logic signed [31:0]   blend_z,
  output logic                 saturated
);
  import mtb_pkg::*;

  logic [KCNT_W-1:0] key_count;
  logic [KCNT_W-1:0] keys_used;
  logic              q_valid;
  logic              q_pop;
  item_t             q_item;

  always_ff @(posedge clk) begin
    if (rst) key_count <= KCNT_W'(1);
    else if (cfg_write) key_count <= cfg_data;
  end

  // clamp to the number of key slots
  assign keys_used = (key_count > KCNT_W'(MAX_KEYS)) ? KCNT_W'(MAX_KEYS) : key_count;

  mtb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .command       (command),
    .key_index     (key_index),
    .vertex_index  (vertex_index),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .coord_z       (coord_z),
    .target_weight (target_weight),
    .ramp_frames   (ramp_frames),
    .keys_used     (keys_used),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  mtb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .keys_used (keys_used),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .blend_x   (blend_x),
    .blend_y   (blend_y),
    .blend_z   (blend_z),
    .saturated (saturated)
  );

endmodule
